// ===== rtl/phic_pkg.sv =====
package phic_pkg;

   // Transaction function codes.
   localparam logic [1:0] FUNC_CLEAR    = 2'd0;
   localparam logic [1:0] FUNC_APPEND   = 2'd1;
   localparam logic [1:0] FUNC_TEST     = 2'd2;
   localparam logic [1:0] FUNC_RESERVED = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_INLIER_DISTANCE = 1'b0;
   localparam logic CSR_MIN_INLIERS     = 1'b1;

   // Sample store size and coordinate width.
   localparam int unsigned SAMPLE_DEPTH = 1024;
   localparam int unsigned COORD_WIDTH  = 16;

   // Fixed field widths.
   localparam int unsigned NORMAL_WIDTH = 34;
   localparam int unsigned OFFSET_WIDTH = 51;
   localparam int unsigned COUNT_WIDTH  = 11;
   localparam int unsigned DIST_WIDTH   = 16;

   // Plane handed from the setup unit to the scan unit.
   typedef struct packed {
      logic signed [NORMAL_WIDTH-1:0] a;
      logic signed [NORMAL_WIDTH-1:0] b;
      logic signed [NORMAL_WIDTH-1:0] c;
      logic signed [OFFSET_WIDTH-1:0] d;
      logic                           degenerate;
   } plane_type;

endpackage

// ===== rtl/plane_hypothesis_inlier_count_core.sv =====
// Plane hypothesis inlier counter.
// Commands on req_func and req_p0..p2 are taken at a rising edge with start
// high and busy low. Clear empties the sample set; append stores req_p0_*
// as the next sample and is ignored once the store is full. Both give no
// response and leave busy low. The reserved code is ignored.
// A test forms the plane through req_p0..p2 and counts the stored samples
// within csr inlier_distance of it, reading one sample per cycle from the
// single read port of the sample memory. The rsp_valid pulse follows the
// plane setup, the sample reads and the drain of the scan pipeline. busy
// falls as the one-cycle response is shown. The receiver cannot stall. A
// degenerate plane scores zero. Reset empties the sample set and loads
// the register defaults; the memory needs no clearing since only stored
// entries are read.
// Configuration writes go through csr_we, csr_index, csr_wdata.
module plane_hypothesis_inlier_count_core
   import phic_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_func,
   input  logic signed [COORD_WIDTH-1:0]  req_p0_x,
   input  logic signed [COORD_WIDTH-1:0]  req_p0_y,
   input  logic signed [COORD_WIDTH-1:0]  req_p0_z,
   input  logic signed [COORD_WIDTH-1:0]  req_p1_x,
   input  logic signed [COORD_WIDTH-1:0]  req_p1_y,
   input  logic signed [COORD_WIDTH-1:0]  req_p1_z,
   input  logic signed [COORD_WIDTH-1:0]  req_p2_x,
   input  logic signed [COORD_WIDTH-1:0]  req_p2_y,
   input  logic signed [COORD_WIDTH-1:0]  req_p2_z,
   output logic                           rsp_valid,
   output logic signed [NORMAL_WIDTH-1:0] rsp_plane_a,
   output logic signed [NORMAL_WIDTH-1:0] rsp_plane_b,
   output logic signed [NORMAL_WIDTH-1:0] rsp_plane_c,
   output logic signed [OFFSET_WIDTH-1:0] rsp_plane_d,
   output logic [COUNT_WIDTH-1:0]         rsp_inlier_count,
   output logic                           rsp_accepted,
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [DIST_WIDTH-1:0]          csr_wdata
);

   localparam int unsigned AW = $clog2(SAMPLE_DEPTH);
   localparam int unsigned CW = $clog2(SAMPLE_DEPTH + 1);
   localparam int unsigned SCAN_LAT = 5;

   typedef enum logic [1:0] {IDLE, SETUP, SCAN, DRAIN} state_type;

   state_type state_ff;
   logic [DIST_WIDTH-1:0]  dist_ff;
   logic [COUNT_WIDTH-1:0] min_ff;
   logic [CW-1:0] fill_ff;
   logic [CW-1:0] rd_ptr_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [2:0] drain_ff;
   logic rd_valid_ff;
   logic rsp_valid_ff;
   logic [NORMAL_WIDTH-1:0] ra_ff, rb_ff, rc_ff;
   logic [OFFSET_WIDTH-1:0] rd_ff;
   logic [COUNT_WIDTH-1:0] rcnt_ff;
   logic racc_ff;

   logic take, go, plane_done, hit, wr_en, rd_issue;
   logic [3*COORD_WIDTH-1:0] rd_data;
   plane_type plane;
   logic [127:0] bound;

   assign take  = start && !busy;
   assign go    = take && (req_func == FUNC_TEST);
   assign wr_en = take && (req_func == FUNC_APPEND) && (fill_ff < CW'(SAMPLE_DEPTH));
   assign rd_issue = (state_ff == SCAN) && (rd_ptr_ff < fill_ff) && !plane.degenerate;
   assign busy  = (state_ff != IDLE);

   phic_plane u_plane (
      .clock, .reset, .go,
      .p0_x(req_p0_x), .p0_y(req_p0_y), .p0_z(req_p0_z),
      .p1_x(req_p1_x), .p1_y(req_p1_y), .p1_z(req_p1_z),
      .p2_x(req_p2_x), .p2_y(req_p2_y), .p2_z(req_p2_z),
      .thresh(dist_ff), .done(plane_done), .plane, .bound
   );

   phic_store #(.SAMPLE_DEPTH(SAMPLE_DEPTH), .COORD_WIDTH(COORD_WIDTH)) u_store (
      .clock, .wr_en,
      .wr_addr(fill_ff[AW-1:0]),
      .wr_data({req_p0_z, req_p0_y, req_p0_x}),
      .rd_addr(rd_ptr_ff[AW-1:0]),
      .rd_data
   );

   phic_scan u_scan (
      .clock, .reset, .in_valid(rd_valid_ff), .sample(rd_data),
      .plane, .bound, .hit
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= DIST_WIDTH'(20);
         min_ff  <= COUNT_WIDTH'(5);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INLIER_DISTANCE: dist_ff <= csr_wdata;
            CSR_MIN_INLIERS:     min_ff  <= csr_wdata[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Sample fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (take && (req_func == FUNC_CLEAR)) begin
         fill_ff <= '0;
      end else if (wr_en) begin
         fill_ff <= fill_ff + 1'b1;
      end
   end

   // Test sequencer and registered response.
   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff    <= IDLE;
         rd_valid_ff <= 1'b0;
         count_ff    <= '0;
         rd_ptr_ff   <= '0;
         drain_ff    <= '0;
      end else begin
         rd_valid_ff <= rd_issue;
         if (hit) begin
            count_ff <= count_ff + 1'b1;
         end
         unique case (state_ff)
            IDLE: begin
               if (go) begin
                  state_ff <= SETUP;
               end
            end
            SETUP: begin
               count_ff  <= '0;
               rd_ptr_ff <= '0;
               if (plane_done) begin
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               if (rd_issue) begin
                  rd_ptr_ff <= rd_ptr_ff + 1'b1;
               end else begin
                  drain_ff <= '0;
                  state_ff <= DRAIN;
               end
            end
            DRAIN: begin
               drain_ff <= drain_ff + 1'b1;
               if (drain_ff == 3'(SCAN_LAT)) begin
                  ra_ff   <= plane.a;
                  rb_ff   <= plane.b;
                  rc_ff   <= plane.c;
                  rd_ff   <= plane.d;
                  rcnt_ff <= count_ff;
                  racc_ff <= (count_ff >= min_ff);
                  rsp_valid_ff <= 1'b1;
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_plane_a      = ra_ff;
   assign rsp_plane_b      = rb_ff;
   assign rsp_plane_c      = rc_ff;
   assign rsp_plane_d      = rd_ff;
   assign rsp_inlier_count = rcnt_ff;
   assign rsp_accepted     = racc_ff;

endmodule

// ===== rtl/phic_plane.sv =====
// Plane setup: forms the normal, the offset and the squared threshold
// bound in a sequence of states, and takes a new go only once idle again.
module phic_plane
   import phic_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic signed [COORD_WIDTH-1:0] p0_x,
   input  logic signed [COORD_WIDTH-1:0] p0_y,
   input  logic signed [COORD_WIDTH-1:0] p0_z,
   input  logic signed [COORD_WIDTH-1:0] p1_x,
   input  logic signed [COORD_WIDTH-1:0] p1_y,
   input  logic signed [COORD_WIDTH-1:0] p1_z,
   input  logic signed [COORD_WIDTH-1:0] p2_x,
   input  logic signed [COORD_WIDTH-1:0] p2_y,
   input  logic signed [COORD_WIDTH-1:0] p2_z,
   input  logic        [DIST_WIDTH-1:0]  thresh,
   output logic                          done,
   output plane_type                     plane,
   output logic        [127:0]           bound
);

   localparam int unsigned DW = COORD_WIDTH + 1;

   typedef enum logic [2:0] {IDLE, CROSS, OFFS, NSQ, NSUM, BND, BSUM} state_type;

   state_type state_ff;
   logic signed [DW-1:0] ux_ff, uy_ff, uz_ff, vx_ff, vy_ff, vz_ff;
   logic signed [COORD_WIDTH-1:0] qx_ff, qy_ff, qz_ff;
   logic signed [NORMAL_WIDTH-1:0] a_ff, b_ff, c_ff;
   logic signed [OFFSET_WIDTH-1:0] d_ff;
   logic signed [OFFSET_WIDTH-1:0] da_ff, db_ff, dc_ff;
   logic [67:0] sa_ff, sb_ff, sc_ff;
   logic [69:0] nsq_ff;
   logic [31:0] t2_ff;
   logic [66:0] blo_ff, bhi_ff;
   logic [127:0] bound_ff;
   logic done_ff;

   logic [NORMAL_WIDTH-1:0] ma, mb, mc;

   // Magnitudes of the normal components.
   assign ma = a_ff[NORMAL_WIDTH-1] ? NORMAL_WIDTH'(-a_ff) : a_ff;
   assign mb = b_ff[NORMAL_WIDTH-1] ? NORMAL_WIDTH'(-b_ff) : b_ff;
   assign mc = c_ff[NORMAL_WIDTH-1] ? NORMAL_WIDTH'(-c_ff) : c_ff;

   // Sequencer: difference vectors, cross product, offset, norm, bound.
   // The bound is formed from two half-width products of the squared norm.
   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (go) begin
                  ux_ff <= DW'(p1_x) - DW'(p0_x);
                  uy_ff <= DW'(p1_y) - DW'(p0_y);
                  uz_ff <= DW'(p1_z) - DW'(p0_z);
                  vx_ff <= DW'(p2_x) - DW'(p0_x);
                  vy_ff <= DW'(p2_y) - DW'(p0_y);
                  vz_ff <= DW'(p2_z) - DW'(p0_z);
                  qx_ff <= p0_x;
                  qy_ff <= p0_y;
                  qz_ff <= p0_z;
                  t2_ff <= 32'(thresh) * 32'(thresh);
                  state_ff <= CROSS;
               end
            end
            CROSS: begin
               a_ff <= NORMAL_WIDTH'(uy_ff * vz_ff) - NORMAL_WIDTH'(uz_ff * vy_ff);
               b_ff <= NORMAL_WIDTH'(uz_ff * vx_ff) - NORMAL_WIDTH'(ux_ff * vz_ff);
               c_ff <= NORMAL_WIDTH'(ux_ff * vy_ff) - NORMAL_WIDTH'(uy_ff * vx_ff);
               state_ff <= OFFS;
            end
            OFFS: begin
               da_ff <= OFFSET_WIDTH'(a_ff * qx_ff);
               db_ff <= OFFSET_WIDTH'(b_ff * qy_ff);
               dc_ff <= OFFSET_WIDTH'(c_ff * qz_ff);
               state_ff <= NSQ;
            end
            NSQ: begin
               d_ff  <= -(da_ff + db_ff + dc_ff);
               sa_ff <= 68'(ma) * 68'(ma);
               sb_ff <= 68'(mb) * 68'(mb);
               sc_ff <= 68'(mc) * 68'(mc);
               state_ff <= NSUM;
            end
            NSUM: begin
               nsq_ff <= 70'(sa_ff) + 70'(sb_ff) + 70'(sc_ff);
               state_ff <= BND;
            end
            BND: begin
               blo_ff <= 67'(nsq_ff[34:0]) * 67'(t2_ff);
               bhi_ff <= 67'(nsq_ff[69:35]) * 67'(t2_ff);
               state_ff <= BSUM;
            end
            BSUM: begin
               bound_ff <= (128'(bhi_ff) << 35) + 128'(blo_ff);
               done_ff  <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign done             = done_ff;
   assign bound            = bound_ff;
   assign plane.a          = a_ff;
   assign plane.b          = b_ff;
   assign plane.c          = c_ff;
   assign plane.d          = d_ff;
   assign plane.degenerate = (a_ff == '0) && (b_ff == '0) && (c_ff == '0);

endmodule

// ===== rtl/phic_store.sv =====
// Sample memory: one write port, one registered read port.
module phic_store #(
   parameter int unsigned SAMPLE_DEPTH = 1024,
   parameter int unsigned COORD_WIDTH  = 16,
   parameter int unsigned AW           = $clog2(SAMPLE_DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [3*COORD_WIDTH-1:0] wr_data,
   input  logic [AW-1:0]            rd_addr,
   output logic [3*COORD_WIDTH-1:0] rd_data
);

   logic [3*COORD_WIDTH-1:0] mem [SAMPLE_DEPTH];
   logic [3*COORD_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/phic_scan.sv =====
// Scan datapath: per sample, residual products, residual sum, magnitude,
// partial squares, square, compare. Fully pipelined at one sample per cycle.
module phic_scan
   import phic_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [3*COORD_WIDTH-1:0]      sample,
   input  plane_type                     plane,
   input  logic [127:0]                  bound,
   output logic                          hit
);

   localparam int unsigned NW = OFFSET_WIDTH + 2;
   localparam int unsigned MW = OFFSET_WIDTH;
   localparam int unsigned LW = 26;
   localparam int unsigned HW = MW - LW;

   logic signed [COORD_WIDTH-1:0] sx, sy, sz;
   logic signed [OFFSET_WIDTH-1:0] px_ff, py_ff, pz_ff;
   logic signed [NW-1:0] n_ff;
   logic [NW-1:0] m;
   logic [MW-1:0] m_ff;
   logic [2*HW-1:0] hh_ff;
   logic [HW+LW-1:0] hl_ff;
   logic [2*LW-1:0] ll_ff;
   logic [127:0] sq_ff;
   logic [4:0] v_ff;

   assign sx = sample[COORD_WIDTH-1:0];
   assign sy = sample[2*COORD_WIDTH-1:COORD_WIDTH];
   assign sz = sample[3*COORD_WIDTH-1:2*COORD_WIDTH];
   assign m  = n_ff[NW-1] ? NW'(-n_ff) : n_ff;

   // Stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   // Products, sum, magnitude, then the square from three half-width products.
   // The residual magnitude stays below 2^51, so it fits the MW-bit register.
   always_ff @(posedge clock) begin
      px_ff <= OFFSET_WIDTH'(plane.a * sx);
      py_ff <= OFFSET_WIDTH'(plane.b * sy);
      pz_ff <= OFFSET_WIDTH'(plane.c * sz);
      n_ff  <= NW'(px_ff) + NW'(py_ff) + NW'(pz_ff) + NW'(plane.d);
      m_ff  <= m[MW-1:0];
      hh_ff <= (2*HW)'(m_ff[MW-1:LW]) * (2*HW)'(m_ff[MW-1:LW]);
      hl_ff <= (HW+LW)'(m_ff[MW-1:LW]) * (HW+LW)'(m_ff[LW-1:0]);
      ll_ff <= (2*LW)'(m_ff[LW-1:0]) * (2*LW)'(m_ff[LW-1:0]);
      sq_ff <= (128'(hh_ff) << (2*LW)) + (128'(hl_ff) << (LW+1)) + 128'(ll_ff);
   end

   assign hit = v_ff[4] && (sq_ff <= bound);

endmodule

// ===== rtl/phic_checker.sv =====
// Port-level checks on the command and response behavior.
module phic_checker
   import phic_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic [1:0]             req_func,
   input logic                   rsp_valid,
   input logic [COUNT_WIDTH-1:0] rsp_inlier_count
);

   // A test command makes the block busy.
   a_test_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_func == FUNC_TEST |=> busy)
      else $error("test command did not raise busy");

   // Clear and append complete at once.
   a_short_cmd: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_func == FUNC_CLEAR || req_func == FUNC_APPEND) |=> !busy)
      else $error("clear or append left the block busy");

   // A response is a single-cycle pulse.
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response held longer than one cycle");

   // The count never exceeds the store size.
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_inlier_count <= COUNT_WIDTH'(SAMPLE_DEPTH))
      else $error("inlier count out of range");

endmodule

bind plane_hypothesis_inlier_count_core phic_checker u_phic_checker (
   .clock, .reset, .start, .busy, .req_func, .rsp_valid, .rsp_inlier_count
);
